FILE: design/rsmp_pkg.sv
`timescale 1ns / 1ps
package rsmp_pkg;

   localparam int COORD_BITS = 32;
   localparam int ARC_W      = 48;
   localparam int WIDE_W     = 81;               // holds |D| * rem and the dividend
   localparam int REM_W      = ARC_W + 2;
   localparam int NP_W       = 7;
   localparam int STEP_W     = 7;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(ARC_W);
   localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(WIDE_W);
   localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(COORD_BITS + 1);
   localparam int SQRT_ALIGN = WIDE_W - 2 * (COORD_BITS + 1);

   localparam logic [NP_W-1:0] NP_MIN   = 7'd2;
   localparam logic [NP_W-1:0] NP_MAX   = 7'd64;
   localparam logic [NP_W-1:0] NP_RESET = 7'd4;

   localparam logic REG_NUM_POINTS = 1'b0;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      logic       accum;
   } alu_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

   typedef logic [2:0][COORD_BITS-1:0] coord_vec_type;

   typedef struct packed {
      coord_vec_type    p;
      logic [ARC_W-1:0] arc;
   } rsmp_row_type;

   // |a - b| for two signed coordinates, one bit wider than a coordinate
   function automatic logic [COORD_BITS:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      abs_diff = d[COORD_BITS] ? (~d + 1'b1) : d;
   endfunction

endpackage

FILE: design/rsmp_alu.sv
`timescale 1ns / 1ps
module rsmp_alu import rsmp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  alu_ctl_type       ctl,
   input  logic [WIDE_W-1:0] opa,
   input  logic [ARC_W-1:0]  opb,
   output alu_sts_type       sts,
   output logic [WIDE_W-1:0] result
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   alu_op_type        op_ff, op_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [WIDE_W-1:0] n_ff, n_in;
   logic [ARC_W-1:0]  b_ff, b_in;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [REM_W-1:0]  rem_ff, rem_in;

   logic [REM_W-1:0]  minuend, subtrahend, diff;
   logic              ge;
   logic [WIDE_W-1:0] mul_sum;

   // one shared compare/subtract serves restoring division and square root
   always_comb begin
      if (op_ff == ALU_DIV) begin
         minuend    = {rem_ff[REM_W-2:0], n_ff[WIDE_W-1]};
         subtrahend = {2'b00, b_ff};
      end else begin
         minuend    = {rem_ff[REM_W-3:0], n_ff[WIDE_W-1:WIDE_W-2]};
         subtrahend = {acc_ff[ARC_W-1:0], 2'b01};
      end
      ge      = minuend >= subtrahend;
      diff    = minuend - subtrahend;
      mul_sum = acc_ff + (b_ff[0] ? n_ff : '0);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      steps_in = steps_ff;
      n_in     = n_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      if (ctl.start && !busy_ff) begin
         op_in   = ctl.op;
         busy_in = 1'b1;
         rem_in  = '0;
         b_in    = opb;
         case (ctl.op)
            ALU_MUL: begin
               n_in     = opa;
               acc_in   = ctl.accum ? acc_ff : '0;
               steps_in = MUL_STEPS;
            end
            ALU_DIV: begin
               n_in     = opa;
               acc_in   = '0;
               steps_in = DIV_STEPS;
            end
            ALU_SQRT: begin
               n_in     = opa << SQRT_ALIGN;
               acc_in   = '0;
               steps_in = SQRT_STEPS;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            ALU_MUL: begin
               acc_in = mul_sum;
               n_in   = n_ff << 1;
               b_in   = b_ff >> 1;
            end
            ALU_DIV: begin
               rem_in = ge ? diff : minuend;
               acc_in = {acc_ff[WIDE_W-2:0], ge};
               n_in   = n_ff << 1;
            end
            ALU_SQRT: begin
               rem_in = ge ? diff : minuend;
               acc_in = {acc_ff[WIDE_W-2:0], ge};
               n_in   = n_ff << 2;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         steps_in = steps_ff - 1'b1;
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      steps_ff <= steps_in;
      n_ff     <= n_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = acc_ff;

endmodule

FILE: design/rsmp_mem.sv
`timescale 1ns / 1ps
module rsmp_mem import rsmp_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic         clock,
   input  logic         coord_we,
   input  logic         arc_we,
   input  logic [AW-1:0] wr_addr,
   input  rsmp_row_type wr_row,
   input  logic [AW-1:0] rd_addr,
   output rsmp_row_type rd_row
);

   logic [COORD_BITS-1:0] mem_x   [DEPTH];
   logic [COORD_BITS-1:0] mem_y   [DEPTH];
   logic [COORD_BITS-1:0] mem_z   [DEPTH];
   logic [ARC_W-1:0]      mem_arc [DEPTH];
   rsmp_row_type          rd_row_ff;

   always_ff @(posedge clock) begin
      if (coord_we) begin
         mem_x[wr_addr] <= wr_row.p[0];
         mem_y[wr_addr] <= wr_row.p[1];
         mem_z[wr_addr] <= wr_row.p[2];
      end
      if (arc_we) begin
         mem_arc[wr_addr] <= wr_row.arc;
      end
      rd_row_ff.p[0] <= mem_x[rd_addr];
      rd_row_ff.p[1] <= mem_y[rd_addr];
      rd_row_ff.p[2] <= mem_z[rd_addr];
      rd_row_ff.arc  <= mem_arc[rd_addr];
   end

   assign rd_row = rd_row_ff;

endmodule

FILE: design/polyline_arc_length_resample.sv
`timescale 1ns / 1ps
// Arc-length resampler for a 3D polyline in signed Q16.16. Vertices come in one item at a
// time and are kept, with their running arc length, in on-chip memory (MAX_VERTICES deep);
// vertices beyond capacity are dropped and flagged on every point of that run via
// rsp_overflow. The item with req_last_vertex set starts the output: num_points points
// (register at address 0, clamped to 2..64, reset 4) evenly spaced in arc length, first and
// last being the end vertices, the last marked by rsp_last_point. Squarings, square root, divides
// and interpolation products run on one shared bit-serial unit (shift-add multiply, restoring
// divide, digit-by-digit square root), so the block takes one item at a time and holds req_stall
// while busy. A stored vertex after the first is held until three 48-step squarings and a 33-step
// root are done; a first vertex, or a non-last vertex beyond capacity, is taken without arithmetic.
// An end point or copied point is emitted directly; an interpolated interior point needs the
// target divide, a scan of the segments, and a multiply and a divide per axis, plus any output
// stall time.
// Memory contents are not cleared by reset; only written entries are ever read.
module polyline_arc_length_resample import rsmp_pkg::*; #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // vertex items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_vert_x,
   input  logic [COORD_BITS-1:0] req_vert_y,
   input  logic [COORD_BITS-1:0] req_vert_z,
   input  logic                  req_last_vertex,
   // point items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_point_x,
   output logic [COORD_BITS-1:0] rsp_point_y,
   output logic [COORD_BITS-1:0] rsp_point_z,
   output logic                  rsp_last_point,
   output logic                  rsp_overflow,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_W-1:0]    paddr,
   input  logic [PDATA_W-1:0]    pwdata,
   output logic [PDATA_W-1:0]    prdata,
   output logic                  pready
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ,        // issue square of one axis delta
      S_SQ_W,
      S_ROOT,
      S_ROOT_W,    // segment length ready, write arc
      S_POINT,     // pick how to make point i
      S_TGT_W,     // target distance divide
      S_RD_LO,
      S_RD_HI,
      S_CHECK,     // does segment j hold the target
      S_EVAL,
      S_LERP,
      S_LMUL_W,
      S_LDIV_W,
      S_OUT_W      // point waits to be taken
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [NP_W-1:0]   np_cfg_ff, np_cfg_in;
   logic [NP_W-1:0]   np_ff, np_in;
   logic              last_v_ff, last_v_in;
   logic [AW-1:0]     k_ff, k_in;
   coord_vec_type     cur_ff, cur_in;
   coord_vec_type     prev_ff, prev_in;
   coord_vec_type     first_ff, first_in;
   logic [ARC_W-1:0]  prev_arc_ff, prev_arc_in;
   logic [1:0]        c_ff, c_in;
   logic [NP_W-1:0]   i_ff, i_in;
   logic [AW-1:0]     seg_ff, seg_in;
   logic [AW-1:0]     j_ff, j_in;
   logic              force_ff, force_in;
   logic [ARC_W-1:0]  d_ff, d_in;
   rsmp_row_type      lo_ff, lo_in;
   rsmp_row_type      hi_ff, hi_in;
   logic [ARC_W-1:0]  rem_ff, rem_in;
   logic [ARC_W-1:0]  seg_len_ff, seg_len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   coord_vec_type     rsp_pt_ff, rsp_pt_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   alu_ctl_type       alu_ctl;
   alu_sts_type       alu_sts;
   logic [WIDE_W-1:0] alu_opa;
   logic [ARC_W-1:0]  alu_opb;
   logic [WIDE_W-1:0] alu_result;

   logic              mem_coord_we, mem_arc_we;
   logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
   rsmp_row_type      mem_wr_row, mem_rd_row;

   logic              req_take, rsp_take, cfg_write;
   logic [NP_W-1:0]   np_clamped;
   logic [CW-1:0]     count_m1;
   logic [AW-1:0]     last_idx;
   logic [AW:0]       j_next;
   logic [COORD_BITS:0] sq_mag, lerp_mag;
   logic              lerp_neg;
   logic [COORD_BITS:0] root;
   logic [ARC_W:0]    arc_sum;
   logic [ARC_W-1:0]  arc_new;
   logic [ARC_W+NP_W-1:0] tgt_num;
   logic [ARC_W-1:0]  eval_seg, eval_rem;
   logic [COORD_BITS-1:0] lerp_val;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_NUM_POINTS);

   assign np_clamped = (np_cfg_ff < NP_MIN) ? NP_MIN :
                       ((np_cfg_ff > NP_MAX) ? NP_MAX : np_cfg_ff);
   assign count_m1   = count_ff - CW'(1);
   assign last_idx   = count_m1[AW-1:0];
   assign j_next     = {1'b0, j_ff} + 1'b1;

   // axis delta for the new segment, and for interpolation
   assign sq_mag   = abs_diff(cur_ff[c_ff], prev_ff[c_ff]);
   assign lerp_mag = abs_diff(hi_ff.p[c_ff], lo_ff.p[c_ff]);
   assign lerp_neg = $signed(hi_ff.p[c_ff]) < $signed(lo_ff.p[c_ff]);
   assign lerp_val = lerp_neg ? (lo_ff.p[c_ff] - alu_result[COORD_BITS-1:0])
                              : (lo_ff.p[c_ff] + alu_result[COORD_BITS-1:0]);

   // arc length saturates at all ones
   assign root    = alu_result[COORD_BITS:0];
   assign arc_sum = {1'b0, prev_arc_ff} + (ARC_W + 1)'(root);
   assign arc_new = arc_sum[ARC_W] ? '1 : arc_sum[ARC_W-1:0];

   assign tgt_num  = {{NP_W{1'b0}}, prev_arc_ff} * {{ARC_W{1'b0}}, i_ff};
   assign eval_seg = hi_ff.arc - lo_ff.arc;
   assign eval_rem = d_ff - lo_ff.arc;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      np_cfg_in    = cfg_write ? pwdata[NP_W-1:0] : np_cfg_ff;
      np_in        = np_ff;
      last_v_in    = last_v_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      prev_arc_in  = prev_arc_ff;
      c_in         = c_ff;
      i_in         = i_ff;
      seg_in       = seg_ff;
      j_in         = j_ff;
      force_in     = force_ff;
      d_in         = d_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rem_in       = rem_ff;
      seg_len_in   = seg_len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pt_in    = rsp_pt_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      alu_ctl.start = 1'b0;
      alu_ctl.op    = ALU_MUL;
      alu_ctl.accum = 1'b0;
      alu_opa       = WIDE_W'(sq_mag);
      alu_opb       = ARC_W'(sq_mag);

      mem_coord_we    = 1'b0;
      mem_arc_we      = 1'b0;
      mem_wr_addr     = k_ff;
      mem_wr_row.p    = {req_vert_z, req_vert_y, req_vert_x};
      mem_wr_row.arc  = arc_new;
      mem_rd_addr     = (state_ff == S_RD_HI) ? j_next[AW-1:0] : j_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               last_v_in = req_last_vertex;
               if (count_ff == '0) begin
                  // first vertex: arc length zero, no segment
                  mem_coord_we   = 1'b1;
                  mem_arc_we     = 1'b1;
                  mem_wr_addr    = '0;
                  mem_wr_row.arc = '0;
                  first_in       = {req_vert_z, req_vert_y, req_vert_x};
                  prev_in        = {req_vert_z, req_vert_y, req_vert_x};
                  prev_arc_in    = '0;
                  count_in       = CW'(1);
               end else if (count_ff < CW'(MAX_VERTICES)) begin
                  mem_coord_we = 1'b1;
                  mem_wr_addr  = count_ff[AW-1:0];
                  k_in         = count_ff[AW-1:0];
                  cur_in       = {req_vert_z, req_vert_y, req_vert_x};
                  count_in     = count_ff + 1'b1;
                  c_in         = 2'd0;
               end else begin
                  dropped_in = 1'b1;
               end
               if (count_ff != '0 && count_ff < CW'(MAX_VERTICES)) begin
                  state_in = S_SQ;
               end else if (req_last_vertex) begin
                  np_in    = np_clamped;
                  i_in     = '0;
                  seg_in   = '0;
                  state_in = S_POINT;
               end
            end
         end
         S_SQ: begin
            alu_ctl.start = 1'b1;
            alu_ctl.op    = ALU_MUL;
            alu_ctl.accum = (c_ff != 2'd0);
            state_in      = S_SQ_W;
         end
         S_SQ_W: begin
            if (alu_sts.done) begin
               if (c_ff == 2'd2) begin
                  state_in = S_ROOT;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = S_SQ;
               end
            end
         end
         S_ROOT: begin
            alu_ctl.start = 1'b1;
            alu_ctl.op    = ALU_SQRT;
            alu_opa       = alu_result;
            state_in      = S_ROOT_W;
         end
         S_ROOT_W: begin
            if (alu_sts.done) begin
               mem_arc_we  = 1'b1;
               prev_arc_in = arc_new;
               prev_in     = cur_ff;
               if (last_v_ff) begin
                  np_in    = np_clamped;
                  i_in     = '0;
                  seg_in   = '0;
                  state_in = S_POINT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_POINT: begin
            rsp_ovf_in = dropped_ff;
            if (i_ff == np_ff - 1'b1) begin
               rsp_pt_in    = prev_ff;
               rsp_last_in  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_OUT_W;
            end else if (i_ff == '0 || count_ff < CW'(2) || prev_arc_ff == '0) begin
               rsp_pt_in    = first_ff;
               rsp_last_in  = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = S_OUT_W;
            end else begin
               // target = i * total / (num_points - 1)
               alu_ctl.start = 1'b1;
               alu_ctl.op    = ALU_DIV;
               alu_opa       = WIDE_W'(tgt_num);
               alu_opb       = ARC_W'(np_ff - 1'b1);
               state_in      = S_TGT_W;
            end
         end
         S_TGT_W: begin
            if (alu_sts.done) begin
               d_in     = alu_result[ARC_W-1:0];
               j_in     = seg_ff;
               force_in = 1'b0;
               state_in = S_RD_LO;
            end
         end
         S_RD_LO: begin
            state_in = S_RD_HI;
         end
         S_RD_HI: begin
            lo_in    = mem_rd_row;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (force_ff || (lo_ff.arc <= d_ff && mem_rd_row.arc > d_ff)) begin
               hi_in    = mem_rd_row;
               seg_in   = j_ff;
               state_in = S_EVAL;
            end else if (j_next < {1'b0, last_idx}) begin
               j_in     = j_next[AW-1:0];
               state_in = S_RD_LO;
            end else begin
               // no segment found: fall back to the current one
               j_in     = seg_ff;
               force_in = 1'b1;
               state_in = S_RD_LO;
            end
         end
         S_EVAL: begin
            if (eval_seg == '0 || d_ff < lo_ff.arc || eval_rem >= eval_seg) begin
               rsp_pt_in    = lo_ff.p;
               rsp_last_in  = 1'b0;
               rsp_ovf_in   = dropped_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_OUT_W;
            end else begin
               rem_in     = eval_rem;
               seg_len_in = eval_seg;
               c_in       = 2'd0;
               state_in   = S_LERP;
            end
         end
         S_LERP: begin
            alu_ctl.start = 1'b1;
            alu_ctl.op    = ALU_MUL;
            alu_opa       = WIDE_W'(lerp_mag);
            alu_opb       = rem_ff;
            state_in      = S_LMUL_W;
         end
         S_LMUL_W: begin
            if (alu_sts.done) begin
               alu_ctl.start = 1'b1;
               alu_ctl.op    = ALU_DIV;
               alu_opa       = alu_result;
               alu_opb       = seg_len_ff;
               state_in      = S_LDIV_W;
            end
         end
         S_LDIV_W: begin
            if (alu_sts.done) begin
               rsp_pt_in[c_ff] = lerp_val;
               if (c_ff == 2'd2) begin
                  rsp_last_in  = 1'b0;
                  rsp_ovf_in   = dropped_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = S_OUT_W;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = S_LERP;
               end
            end
         end
         S_OUT_W: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_POINT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      np_ff       <= np_in;
      last_v_ff   <= last_v_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      first_ff    <= first_in;
      prev_arc_ff <= prev_arc_in;
      c_ff        <= c_in;
      i_ff        <= i_in;
      seg_ff      <= seg_in;
      j_ff        <= j_in;
      force_ff    <= force_in;
      d_ff        <= d_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rem_ff      <= rem_in;
      seg_len_ff  <= seg_len_in;
      rsp_pt_ff   <= rsp_pt_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         np_cfg_ff    <= NP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         np_cfg_ff    <= np_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rsmp_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .opa    (alu_opa),
      .opb    (alu_opb),
      .sts    (alu_sts),
      .result (alu_result)
   );

   rsmp_mem #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .coord_we (mem_coord_we),
      .arc_we   (mem_arc_we),
      .wr_addr  (mem_wr_addr),
      .wr_row   (mem_wr_row),
      .rd_addr  (mem_rd_addr),
      .rd_row   (mem_rd_row)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_pt_ff[0];
   assign rsp_point_y    = rsp_pt_ff[1];
   assign rsp_point_z    = rsp_pt_ff[2];
   assign rsp_last_point = rsp_last_ff;
   assign rsp_overflow   = rsp_ovf_ff;
   assign pready         = 1'b1;
   assign prdata         = (paddr[PADDR_W-1] == REG_NUM_POINTS) ? PDATA_W'(np_cfg_ff) : '0;

   // the shared unit is never restarted mid-operation
   a_alu_no_restart: assert property (@(posedge clock) disable iff (reset)
      alu_sts.busy |-> !alu_ctl.start)
      else $error("shared unit started while busy");

   // stored vertex count stays within capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("vertex count beyond capacity");

   // final point of a run leaves the store empty and the drop flag clear
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_ff) |=> (count_ff == '0 && !dropped_ff && state_ff == S_IDLE))
      else $error("run did not close after final point");

   // points appear only once the stored run has at least one vertex
   a_point_has_vertex: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (count_ff != '0))
      else $error("point issued with empty store");

endmodule

FILE: verif/polyline_arc_length_resample_tb.sv
`timescale 1ns / 1ps
module polyline_arc_length_resample_tb;
   import rsmp_pkg::*;

   localparam int DEPTH     = 64;
   localparam int CYCLE_CAP = 20000000;

   typedef struct {
      logic [31:0] x, y, z;
      logic        tail;
   } vertex_type;

   typedef struct {
      logic [31:0] x, y, z;
      logic        tail, ovf;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_vert_x = '0, req_vert_y = '0, req_vert_z = '0;
   logic        req_last_vertex = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic        rsp_last_point, rsp_overflow;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   polyline_arc_length_resample DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vert_x(req_vert_x), .req_vert_y(req_vert_y), .req_vert_z(req_vert_z),
      .req_last_vertex(req_last_vertex),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y), .rsp_point_z(rsp_point_z),
      .rsp_last_point(rsp_last_point), .rsp_overflow(rsp_overflow),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expectation stores
   vertex_type pending_verts[$];
   point_type  expected_points[$];

   // predictor state: stored vertices, running arc length, count, drop flag, register
   logic [31:0] pv_x[DEPTH], pv_y[DEPTH], pv_z[DEPTH];
   logic [47:0] pv_arc[DEPTH];
   int          pv_count = 0;
   bit          pv_dropped = 1'b0;
   logic [6:0]  pv_num_points = NP_RESET;

   int  fail_count = 0;
   int  points_checked = 0;
   int  polylines_done = 0;
   int  drop_runs = 0;
   int  cycle_count = 0;
   bit  idle_en = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;

   task automatic report(input string what);
      fail_count++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // integer square root, digit by digit over bit pairs
   function automatic logic [33:0] root_of(input logic [65:0] s);
      logic [67:0] rem;
      logic [67:0] trial;
      logic [33:0] root;
      rem  = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem   = (rem << 2) | 68'(s[2*i +: 2]);
         trial = (68'(root) << 2) | 68'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 34'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic [32:0] span(input logic [31:0] a, input logic [31:0] b);
      logic signed [32:0] d;
      d = $signed({b[31], b}) - $signed({a[31], a});
      return d < 0 ? 33'(-d) : 33'(d);
   endfunction

   // interpolation truncating toward a
   function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                         input logic [47:0] rem, input logic [47:0] seg);
      logic signed [32:0] d;
      logic [127:0]       part;
      d    = $signed({b[31], b}) - $signed({a[31], a});
      part = (128'(span(a, b)) * 128'(rem)) / 128'(seg);
      return d < 0 ? a - part[31:0] : a + part[31:0];
   endfunction

   function automatic point_type mk_point(input logic [31:0] x, y, z, input logic tail);
      point_type p;
      p.x = x; p.y = y; p.z = z; p.tail = tail; p.ovf = pv_dropped;
      return p;
   endfunction

   task automatic expect_point(input point_type p);
      expected_points.insert(expected_points.size(), p);
   endtask

   // store one vertex and, on the closing vertex, queue the resampled points
   task automatic resample_vertex(input vertex_type v);
      logic [65:0] sq;
      logic [48:0] sum;
      logic [32:0] dx, dy, dz;
      logic [47:0] total, d, rem, seg;
      int          np, n, tail_i, seg_i;
      if (pv_count < DEPTH) begin
         pv_x[pv_count] = v.x; pv_y[pv_count] = v.y; pv_z[pv_count] = v.z;
         if (pv_count == 0) begin
            pv_arc[0] = '0;
         end else begin
            dx = span(pv_x[pv_count-1], v.x);
            dy = span(pv_y[pv_count-1], v.y);
            dz = span(pv_z[pv_count-1], v.z);
            sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
            sum = 49'(pv_arc[pv_count-1]) + 49'(root_of(sq));
            pv_arc[pv_count] = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
         end
         pv_count++;
      end else begin
         pv_dropped = 1'b1;
      end
      if (!v.tail) return;

      np = pv_num_points < NP_MIN ? NP_MIN : (pv_num_points > NP_MAX ? NP_MAX : pv_num_points);
      n = pv_count;
      tail_i = n - 1;
      total = pv_arc[tail_i];
      if (pv_dropped) drop_runs++;
      expect_point(mk_point(pv_x[0], pv_y[0], pv_z[0], 1'b0));
      seg_i = 0;
      for (int i = 1; i < np - 1; i++) begin
         if (n < 2 || total == 0) begin
            expect_point(mk_point(pv_x[0], pv_y[0], pv_z[0], 1'b0));
            continue;
         end
         d = 48'((64'(i) * 64'(total)) / 64'(np - 1));
         for (int j = seg_i; j < tail_i; j++) begin
            if (pv_arc[j] <= d && pv_arc[j+1] > d) begin
               seg_i = j;
               break;
            end
         end
         seg = pv_arc[seg_i+1] - pv_arc[seg_i];
         rem = d - pv_arc[seg_i];
         if (seg == 0 || d < pv_arc[seg_i] || rem >= seg) begin
            expect_point(mk_point(pv_x[seg_i], pv_y[seg_i], pv_z[seg_i], 1'b0));
            continue;
         end
         expect_point(mk_point(
            blend(pv_x[seg_i], pv_x[seg_i+1], rem, seg),
            blend(pv_y[seg_i], pv_y[seg_i+1], rem, seg),
            blend(pv_z[seg_i], pv_z[seg_i+1], rem, seg), 1'b0));
      end
      expect_point(mk_point(pv_x[tail_i], pv_y[tail_i], pv_z[tail_i], 1'b1));
      pv_count = 0;
      pv_dropped = 1'b0;
      polylines_done++;
   endtask

   // driver: one vertex at a time from the pending queue, random gaps while idling is on
   always @(posedge clock) begin
      vertex_type v;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_verts.size() > 0) begin
            v = pending_verts.pop_front();
            req_vert_x <= v.x;
            req_vert_y <= v.y;
            req_vert_z <= v.z;
            req_last_vertex <= v.tail;
            req_valid <= 1'b1;
            if (idle_en && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // accepted vertices feed the predictor
   always @(posedge clock) begin
      vertex_type v;
      if (!reset && req_valid && !req_stall) begin
         v.x = req_vert_x; v.y = req_vert_y; v.z = req_vert_z; v.tail = req_last_vertex;
         resample_vertex(v);
      end
   end

   // result side: random stall bursts, then compare each accepted point
   always @(posedge clock) begin
      point_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report("point emitted with nothing expected");
         end else begin
            e = expected_points.pop_front();
            points_checked++;
            if (rsp_point_x !== e.x)
               report($sformatf("point_x got %h want %h", rsp_point_x, e.x));
            if (rsp_point_y !== e.y)
               report($sformatf("point_y got %h want %h", rsp_point_y, e.y));
            if (rsp_point_z !== e.z)
               report($sformatf("point_z got %h want %h", rsp_point_z, e.z));
            if (rsp_last_point !== e.tail)
               report($sformatf("last_point got %b want %b", rsp_last_point, e.tail));
            if (rsp_overflow !== e.ovf)
               report($sformatf("overflow got %b want %b", rsp_overflow, e.ovf));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // wait until every queued vertex went in and every point came out
   task automatic drain();
      do @(negedge clock);
      while (pending_verts.size() > 0 || req_valid || expected_points.size() > 0);
   endtask

   // register write with readback; block is idle here
   task automatic csr_write(input logic [6:0] val);
      drain();
      repeat (50) @(negedge clock);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= PADDR_W'(REG_NUM_POINTS); pwdata <= 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      pv_num_points = val;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[6:0] !== val) report($sformatf("num_points reads %h want %h", prdata, val));
      psel <= 1'b0; penable <= 1'b0;
   endtask

   function automatic logic [31:0] pick_coord(input int style);
      case (style)
         0: return $urandom();
         1: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   task automatic add_vertex(input logic [31:0] x, y, z, input logic tail);
      vertex_type v;
      v.x = x; v.y = y; v.z = z; v.tail = tail;
      pending_verts.insert(pending_verts.size(), v);
   endtask

   // a random polyline; some vertices repeat the previous one (zero-length segment)
   task automatic add_polyline(input int n, input int style);
      logic [31:0] x, y, z;
      for (int i = 0; i < n; i++) begin
         if (i == 0 || $urandom_range(0, 7) != 0) begin
            x = pick_coord(style); y = pick_coord(style); z = pick_coord(style);
         end
         add_vertex(x, y, z, i == n - 1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset setting of four points
      add_vertex(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);   // lone vertex
      add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);   // corner to corner
      add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      add_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b0);           // zero total length
      add_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b0);
      add_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b1);
      add_vertex(32'h0, 32'h0, 32'h0, 1'b0);                          // descending axes
      add_vertex(32'hFFFD_0000, 32'h0003_0000, 32'hFFFF_FFFF, 1'b0);
      add_vertex(32'hFFFD_0000, 32'h0003_0000, 32'hFFFF_FFFF, 1'b0);  // repeated vertex
      add_vertex(32'h0005_8000, 32'hFFF0_0000, 32'h0000_0001, 1'b1);
      add_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      add_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
      drain();

      // fewest points, then the range limits and out-of-range register values
      csr_write(7'd2);
      add_vertex(32'h0, 32'h0, 32'h0, 1'b0);
      add_vertex(32'h0010_0000, 32'h0, 32'h0, 1'b1);
      add_polyline(3, 1);
      csr_write(7'd64);
      add_polyline(5, 1);
      add_vertex(32'h0, 32'h0, 32'h0, 1'b1);
      csr_write(7'd0);
      add_polyline(3, 0);
      csr_write(7'd127);
      add_polyline(4, 2);

      // random part; capacity overflow with the closing vertex dropped
      idle_en = 1'b1;
      csr_write(7'd3);
      add_polyline(66, 1);
      drain();                          // sender holds until all points are back
      add_polyline(2, 2);
      csr_write(7'($urandom_range(5, 12)));
      for (int k = 0; k < 3; k++) add_polyline($urandom_range(1, 4), $urandom_range(0, 2));
      csr_write(7'd1);
      for (int k = 0; k < 2; k++) add_polyline($urandom_range(1, 3), $urandom_range(0, 2));
      csr_write(7'($urandom_range(13, 40)));
      add_polyline($urandom_range(2, 4), 0);
      drain();

      // closing stretch with no idling
      idle_en = 1'b0;
      csr_write(7'd6);
      for (int k = 0; k < 2; k++) add_polyline($urandom_range(1, 3), $urandom_range(0, 2));

      drain();
      repeat (200) @(negedge clock);
      $display("Covered %0d polylines, %0d points checked, %0d runs with dropped vertices,",
               polylines_done, points_checked, drop_runs);
      $display("point counts from 2 to 64 including clamped register values.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
